// File: design/dsf_pkg.sv
// ----------------------------------------------------------------------------
// Datagram sequence filter package
// Shared constants, field widths and the verdict status codes.
// ----------------------------------------------------------------------------
package dsf_pkg;

   // Field widths of the transaction payloads
   localparam int LinkIndexW = 4;
   localparam int RxByteW    = 8;
   localparam int LimitW     = 11;
   localparam int DataWordW  = 16;
   localparam int WordPosW   = 10;
   localparam int CountW     = 16;
   localparam int SeqW       = 32;
   localparam int EnabledW   = 10;

   // Header layout: magic word, sequence number and word count, big-endian
   localparam int MagicBytes = 4;
   localparam int SeqBytes   = 4;
   localparam int HdrBytes   = 2 * 4 + 2;
   localparam logic [31:0] MagicWord = {8'h48, 8'h33, 8'h31, 8'h36};

   // Defaults for the top-level parameters
   localparam int DefaultLinks    = 10;
   localparam int DefaultMaxWords = 1024;

   typedef enum logic [2:0] {
      ST_IN_SEQUENCE    = 3'd0,
      ST_GAP_RESYNC     = 3'd1,
      ST_RESTART_RESYNC = 3'd2,
      ST_SHORT          = 3'd3,
      ST_MAGIC          = 3'd4,
      ST_LENGTH         = 3'd5,
      ST_STALE          = 3'd6,
      ST_BAD_LINK       = 3'd7
   } status_type;

endpackage

// File: design/dsf_req_if.sv
// ----------------------------------------------------------------------------
// Datagram byte channel
// One received byte per transaction, tagged with its link and a last flag.
// ----------------------------------------------------------------------------
interface dsf_req_if;

   logic                            valid;
   logic                            ready;
   logic [dsf_pkg::LinkIndexW-1:0]  link_index;
   logic [dsf_pkg::RxByteW-1:0]     rx_byte;
   logic                            end_of_datagram;
   logic [dsf_pkg::LimitW-1:0]      buffer_limit;

   modport source (
      output valid, link_index, rx_byte, end_of_datagram, buffer_limit,
      input  ready
   );

   modport sink (
      input  valid, link_index, rx_byte, end_of_datagram, buffer_limit,
      output ready
   );

endinterface

// File: design/dsf_rsp_if.sv
// ----------------------------------------------------------------------------
// Filter result channel
// Tentative data words and the final verdict of each datagram.
// ----------------------------------------------------------------------------
interface dsf_rsp_if;

   logic                            valid;
   logic                            ready;
   logic                            verdict;
   logic [dsf_pkg::DataWordW-1:0]   data_word;
   logic [dsf_pkg::WordPosW-1:0]    word_position;
   logic                            store_allowed;
   dsf_pkg::status_type             status;
   logic [dsf_pkg::CountW-1:0]      word_count;
   logic [dsf_pkg::SeqW-1:0]        packet_sequence;

   modport source (
      output valid, verdict, data_word, word_position, store_allowed, status,
             word_count, packet_sequence,
      input  ready
   );

   modport sink (
      input  valid, verdict, data_word, word_position, store_allowed, status,
             word_count, packet_sequence,
      output ready
   );

endinterface

// File: design/dsf_csr_if.sv
// ----------------------------------------------------------------------------
// Filter configuration channel
// Writes the enabled-links register, one bit per link.
// ----------------------------------------------------------------------------
interface dsf_csr_if;

   logic                            valid;
   logic                            ready;
   logic [dsf_pkg::EnabledW-1:0]    enabled_links;

   modport source (
      output valid, enabled_links,
      input  ready
   );

   modport sink (
      input  valid, enabled_links,
      output ready
   );

endinterface

// File: design/datagram_sequence_filter_unit.sv
// ----------------------------------------------------------------------------
// Datagram sequence filter
// Parses datagram headers, emits data words and judges each datagram against
// the expected sequence number of its link.
// ----------------------------------------------------------------------------
// The unit takes one datagram byte per clock cycle, for any mix of links,
// while the result queue has room for the judging stage to drain. A byte
// passes through a parse stage and a judging stage into a result queue. A
// byte yields at most one data word; the last byte of a datagram yields its
// verdict as well, and needs two result transactions if it has a word. The
// expected sequence numbers live in a per-link synchronous memory that is read
// when a byte is accepted and written back when its verdict is formed; a
// back-to-back datagram on the same link picks up the written value through a
// bypass register. Setting a bit of enabled_links opens that link and resets
// its expected sequence to zero.
// ----------------------------------------------------------------------------
module datagram_sequence_filter_unit #(
   parameter int LINKS     = dsf_pkg::DefaultLinks,
   parameter int MAX_WORDS = dsf_pkg::DefaultMaxWords
) (
   input  logic        clock,
   input  logic        reset,
   dsf_req_if.sink     req_if,
   dsf_rsp_if.source   rsp_if,
   dsf_csr_if.sink     csr_if
);

   localparam int Hdr    = dsf_pkg::HdrBytes;
   localparam int PosCap = Hdr + 2 * MAX_WORDS + 1;
   localparam int PosW   = $clog2(PosCap + 1);
   localparam int LinkW  = (LINKS > 1) ? $clog2(LINKS) : 1;
   localparam int OutDepth = 4;
   localparam int OutPtrW  = 2;

   typedef struct packed {
      logic                            verdict;
      logic [dsf_pkg::DataWordW-1:0]   data_word;
      logic [dsf_pkg::WordPosW-1:0]    word_position;
      logic                            store_allowed;
      dsf_pkg::status_type             status;
      logic [dsf_pkg::CountW-1:0]      word_count;
      logic [dsf_pkg::SeqW-1:0]        packet_sequence;
   } item_type;

   // Configuration and per-link state
   logic [dsf_pkg::EnabledW-1:0] enabled_ff;
   logic [LINKS-1:0]             seq_valid_ff;
   logic [31:0]                  seq_mem [LINKS];
   logic [31:0]                  rdata_ff;

   // Parser state
   logic [PosW-1:0]  pos_ff, pos_in;
   logic [31:0]      magic_ff, magic_in;
   logic [31:0]      hseq_ff, hseq_in;
   logic [15:0]      count_ff, count_in;
   logic [7:0]       pend_ff, pend_in;

   // Judging stage
   logic             s1_valid_ff;
   logic             s1_word_ff;
   logic             s1_last_ff;
   logic [15:0]      s1_data_ff;
   logic [9:0]       s1_wpos_ff;
   logic             s1_store_ff;
   logic             s1_link_ok_ff;
   logic [LinkW-1:0] s1_idx_ff;
   logic [31:0]      s1_magic_ff;
   logic [31:0]      s1_seq_ff;
   logic [15:0]      s1_count_ff;
   logic [PosW-1:0]  s1_len_ff;
   logic             s1_byp_ff;
   logic [31:0]      s1_byp_data_ff;

   // Result queue
   item_type               out_fifo_ff [OutDepth];
   logic [OutPtrW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [OutPtrW:0]       out_count_ff;

   logic                   req_fire, rsp_fire, csr_fire, s1_fire;
   logic [PosW-1:0]        off;
   logic                   word_hit;
   logic [PosW-2:0]        wp;
   logic [LinkW-1:0]       rd_idx;
   logic                   link_in_range, link_ok;
   logic [31:0]            exp_seq;
   dsf_pkg::status_type    status;
   logic                   accept_seq;
   logic                   mem_we;
   logic [31:0]            mem_wdata;
   logic [OutPtrW:0]       push_n;
   item_type               word_item, verdict_item;
   logic [dsf_pkg::EnabledW-1:0] rise;

   assign req_fire = req_if.valid & req_if.ready;
   assign rsp_fire = rsp_if.valid & rsp_if.ready;
   assign csr_fire = csr_if.valid & csr_if.ready;
   assign csr_if.ready = 1'b1;

   // A stage may drain only while the queue has room for both of its results
   assign s1_fire      = s1_valid_ff & (out_count_ff <= (OutPtrW + 1)'(OutDepth - 2));
   assign req_if.ready = ~s1_valid_ff | s1_fire;

   // ---------------------------------------------------------------- parse
   assign off = pos_ff - PosW'(Hdr);
   assign wp  = off[PosW-1:1];

   always_comb begin
      magic_in = magic_ff;
      hseq_in  = hseq_ff;
      count_in = count_ff;
      pend_in  = pend_ff;
      pos_in   = pos_ff;
      word_hit = 1'b0;
      if (pos_ff < PosW'(dsf_pkg::MagicBytes)) begin
         magic_in = {magic_ff[23:0], req_if.rx_byte};
      end else if (pos_ff < PosW'(dsf_pkg::MagicBytes + dsf_pkg::SeqBytes)) begin
         hseq_in = {hseq_ff[23:0], req_if.rx_byte};
      end else if (pos_ff < PosW'(Hdr)) begin
         count_in = {count_ff[7:0], req_if.rx_byte};
      end else if (pos_ff < PosW'(PosCap - 1)) begin
         if (!off[0]) begin
            pend_in = req_if.rx_byte;
         end else begin
            word_hit = 1'b1;
         end
      end
      // Position saturates so that an oversize datagram still fails the length check
      if (pos_ff < PosW'(PosCap)) begin
         pos_in = pos_ff + PosW'(1);
      end
   end

   assign link_in_range = (32'(req_if.link_index) < LINKS);
   assign link_ok = link_in_range && (req_if.link_index < 4'(dsf_pkg::EnabledW)) &&
                    enabled_ff[req_if.link_index];
   assign rd_idx  = link_in_range ? req_if.link_index[LinkW-1:0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         magic_ff <= '0;
         hseq_ff  <= '0;
         count_ff <= '0;
         pend_ff  <= '0;
      end else if (req_fire) begin
         if (req_if.end_of_datagram) begin
            pos_ff   <= '0;
            magic_ff <= '0;
            hseq_ff  <= '0;
            count_ff <= '0;
            pend_ff  <= '0;
         end else begin
            pos_ff   <= pos_in;
            magic_ff <= magic_in;
            hseq_ff  <= hseq_in;
            count_ff <= count_in;
            pend_ff  <= pend_in;
         end
      end
   end

   // Payload of the judging stage; the header values are those after this byte
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_word_ff     <= word_hit;
         s1_last_ff     <= req_if.end_of_datagram;
         s1_data_ff     <= {pend_ff, req_if.rx_byte};
         s1_wpos_ff     <= 10'(wp);
         s1_store_ff    <= (32'(wp) < 32'(req_if.buffer_limit));
         s1_link_ok_ff  <= link_ok;
         s1_idx_ff      <= rd_idx;
         s1_magic_ff    <= magic_in;
         s1_seq_ff      <= hseq_in;
         s1_count_ff    <= count_in;
         s1_len_ff      <= pos_in;
         // The preceding verdict may be writing the very entry being read now
         s1_byp_ff      <= mem_we && (s1_idx_ff == rd_idx);
         s1_byp_data_ff <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // ---------------------------------------------------------------- memory
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rdata_ff <= seq_mem[rd_idx];
      end
      if (mem_we) begin
         seq_mem[s1_idx_ff] <= mem_wdata;
      end
   end

   // An entry whose valid bit is clear reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff   <= '0;
         seq_valid_ff <= '0;
      end else begin
         if (csr_fire) begin
            enabled_ff <= csr_if.enabled_links;
            for (int i = 0; i < LINKS; i++) begin
               if (i < dsf_pkg::EnabledW) begin
                  if (rise[i]) begin
                     seq_valid_ff[i] <= 1'b0;
                  end
               end
            end
         end
         if (mem_we) begin
            seq_valid_ff[s1_idx_ff] <= 1'b1;
         end
      end
   end

   assign rise = csr_if.enabled_links & ~enabled_ff;

   // ---------------------------------------------------------------- judge
   always_comb begin
      if (s1_byp_ff) begin
         exp_seq = s1_byp_data_ff;
      end else if (seq_valid_ff[s1_idx_ff]) begin
         exp_seq = rdata_ff;
      end else begin
         exp_seq = '0;
      end
   end

   always_comb begin
      accept_seq = 1'b0;
      priority if (!s1_link_ok_ff) begin
         status = dsf_pkg::ST_BAD_LINK;
      end else if (s1_len_ff < PosW'(Hdr)) begin
         status = dsf_pkg::ST_SHORT;
      end else if (s1_magic_ff != dsf_pkg::MagicWord) begin
         status = dsf_pkg::ST_MAGIC;
      end else if (32'(s1_len_ff) != 32'(Hdr) + 32'({s1_count_ff, 1'b0})) begin
         status = dsf_pkg::ST_LENGTH;
      end else if ((s1_seq_ff == '0) && (exp_seq != '0)) begin
         status     = dsf_pkg::ST_RESTART_RESYNC;
         accept_seq = 1'b1;
      end else if (s1_seq_ff < exp_seq) begin
         status = dsf_pkg::ST_STALE;
      end else if (s1_seq_ff != exp_seq) begin
         status     = dsf_pkg::ST_GAP_RESYNC;
         accept_seq = 1'b1;
      end else begin
         status     = dsf_pkg::ST_IN_SEQUENCE;
         accept_seq = 1'b1;
      end
   end

   assign mem_we    = s1_fire & s1_last_ff & accept_seq;
   assign mem_wdata = s1_seq_ff + 32'd1;

   always_comb begin
      word_item.verdict         = 1'b0;
      word_item.data_word       = s1_data_ff;
      word_item.word_position   = s1_wpos_ff;
      word_item.store_allowed   = s1_store_ff;
      word_item.status          = dsf_pkg::ST_IN_SEQUENCE;
      word_item.word_count      = s1_count_ff;
      word_item.packet_sequence = s1_seq_ff;

      verdict_item.verdict         = 1'b1;
      verdict_item.data_word       = '0;
      verdict_item.word_position   = '0;
      verdict_item.store_allowed   = 1'b0;
      verdict_item.status          = status;
      verdict_item.word_count      = s1_count_ff;
      verdict_item.packet_sequence = s1_seq_ff;
   end

   // ---------------------------------------------------------------- output
   assign push_n = s1_fire ? ((OutPtrW + 1)'(s1_word_ff) + (OutPtrW + 1)'(s1_last_ff)) : '0;

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         if (s1_word_ff) begin
            out_fifo_ff[wr_ptr_ff] <= word_item;
         end
         if (s1_last_ff) begin
            out_fifo_ff[wr_ptr_ff + OutPtrW'(s1_word_ff)] <= verdict_item;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         out_count_ff <= '0;
      end else begin
         wr_ptr_ff    <= wr_ptr_ff + push_n[OutPtrW-1:0];
         rd_ptr_ff    <= rd_ptr_ff + OutPtrW'(rsp_fire);
         out_count_ff <= out_count_ff + push_n - (OutPtrW + 1)'(rsp_fire);
      end
   end

   assign rsp_if.valid           = (out_count_ff != '0);
   assign rsp_if.verdict         = out_fifo_ff[rd_ptr_ff].verdict;
   assign rsp_if.data_word       = out_fifo_ff[rd_ptr_ff].data_word;
   assign rsp_if.word_position   = out_fifo_ff[rd_ptr_ff].word_position;
   assign rsp_if.store_allowed   = out_fifo_ff[rd_ptr_ff].store_allowed;
   assign rsp_if.status          = out_fifo_ff[rd_ptr_ff].status;
   assign rsp_if.word_count      = out_fifo_ff[rd_ptr_ff].word_count;
   assign rsp_if.packet_sequence = out_fifo_ff[rd_ptr_ff].packet_sequence;

endmodule

// File: tb/datagram_sequence_filter_checker.sv
// ----------------------------------------------------------------------------
// Datagram sequence filter checker
// Watches the byte, result and configuration channels, keeps its own copy of
// the parser and per-link sequence state, and compares every result
// transaction with the oldest predicted one.
// ----------------------------------------------------------------------------
module datagram_sequence_filter_checker (
   input  logic  clock,
   input  logic  reset,
   dsf_req_if    req_mon,
   dsf_rsp_if    rsp_mon,
   dsf_csr_if    csr_mon,
   output int    fail_count,
   output int    pending_count
);

   import dsf_pkg::*;

   localparam int Links    = DefaultLinks;
   localparam int MaxWords = DefaultMaxWords;
   localparam int PosCap   = HdrBytes + 2 * MaxWords + 1;
   localparam int PrintCap = 100;

   typedef struct {
      logic                  verdict;
      logic [DataWordW-1:0]  data_word;
      logic [WordPosW-1:0]   word_position;
      logic                  store_allowed;
      status_type            status;
      logic [CountW-1:0]     word_count;
      logic [SeqW-1:0]       packet_sequence;
   } filter_result_t;

   filter_result_t        predicted_results[$];
   logic [SeqW-1:0]       link_next_seq [Links];
   logic [EnabledW-1:0]   open_links;
   int                    octet_count;
   logic [31:0]           magic_acc;
   logic [SeqW-1:0]       seq_acc;
   logic [CountW-1:0]     count_acc;
   logic [7:0]            high_octet;
   int                    lines_printed;

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      if (lines_printed < PrintCap) begin
         $display("%0t: mismatch in %s: expected 0x%0h, got 0x%0h", $realtime, what, want,
                  got);
      end
      lines_printed++;
      fail_count++;
   endtask

   task automatic clear_parser();
      octet_count = 0;
      magic_acc   = '0;
      seq_acc     = '0;
      count_acc   = '0;
      high_octet  = '0;
   endtask

   task automatic push_result(input logic v, input logic [15:0] word, input logic [9:0] wpos,
                              input logic store, input status_type st);
      filter_result_t r;
      r.verdict         = v;
      r.data_word       = word;
      r.word_position   = wpos;
      r.store_allowed   = store;
      r.status          = st;
      r.word_count      = count_acc;
      r.packet_sequence = seq_acc;
      predicted_results.push_back(r);
   endtask

   // A link whose enable bit rises starts again from sequence zero.
   task automatic apply_link_mask(input logic [EnabledW-1:0] value);
      logic [EnabledW-1:0] rising;
      rising = value & ~open_links;
      for (int i = 0; i < Links; i++) begin
         if (rising[i]) begin
            link_next_seq[i] = '0;
         end
      end
      open_links = value;
   endtask

   task automatic parse_octet(input logic [3:0] link, input logic [7:0] octet,
                              input logic last, input logic [10:0] limit);
      int          pos;
      int          offset;
      int          wpos;
      logic        link_ok;
      logic [31:0] want_seq;
      status_type  st;
      pos = octet_count;
      if (pos < MagicBytes) begin
         magic_acc = {magic_acc[23:0], octet};
      end else if (pos < MagicBytes + SeqBytes) begin
         seq_acc = {seq_acc[23:0], octet};
      end else if (pos < HdrBytes) begin
         count_acc = {count_acc[7:0], octet};
      end else if (pos < PosCap - 1) begin
         offset = pos - HdrBytes;
         if (offset % 2 == 0) begin
            high_octet = octet;
         end else begin
            wpos = offset / 2;
            push_result(1'b0, {high_octet, octet}, 10'(wpos), wpos < int'(limit),
                        ST_IN_SEQUENCE);
         end
      end
      if (pos < PosCap) begin
         octet_count = pos + 1;
      end

      if (last) begin
         link_ok = 1'b0;
         if (link < Links) begin
            link_ok = open_links[link];
         end
         if (!link_ok) begin
            st = ST_BAD_LINK;
         end else if (octet_count < HdrBytes) begin
            st = ST_SHORT;
         end else if (magic_acc != MagicWord) begin
            st = ST_MAGIC;
         end else if (octet_count != HdrBytes + 2 * int'(count_acc)) begin
            st = ST_LENGTH;
         end else begin
            want_seq = link_next_seq[link];
            if (seq_acc == 0 && want_seq != 0) begin
               st = ST_RESTART_RESYNC;
            end else if (seq_acc < want_seq) begin
               st = ST_STALE;
            end else if (seq_acc != want_seq) begin
               st = ST_GAP_RESYNC;
            end else begin
               st = ST_IN_SEQUENCE;
            end
            if (st != ST_STALE) begin
               link_next_seq[link] = seq_acc + 32'd1;
            end
         end
         push_result(1'b1, '0, '0, 1'b0, st);
         clear_parser();
      end
   endtask

   task automatic check_result();
      filter_result_t want;
      if (predicted_results.size() == 0) begin
         report_mismatch("result with none outstanding", 32'd0, 32'(rsp_mon.verdict));
      end else begin
         want = predicted_results.pop_front();
         if (rsp_mon.verdict !== want.verdict)
            report_mismatch("verdict", 32'(want.verdict), 32'(rsp_mon.verdict));
         if (rsp_mon.data_word !== want.data_word)
            report_mismatch("data_word", 32'(want.data_word), 32'(rsp_mon.data_word));
         if (rsp_mon.word_position !== want.word_position)
            report_mismatch("word_position", 32'(want.word_position),
                            32'(rsp_mon.word_position));
         if (rsp_mon.store_allowed !== want.store_allowed)
            report_mismatch("store_allowed", 32'(want.store_allowed),
                            32'(rsp_mon.store_allowed));
         if (rsp_mon.status !== want.status)
            report_mismatch("status", 32'(want.status), 32'(rsp_mon.status));
         if (rsp_mon.word_count !== want.word_count)
            report_mismatch("word_count", 32'(want.word_count), 32'(rsp_mon.word_count));
         if (rsp_mon.packet_sequence !== want.packet_sequence)
            report_mismatch("packet_sequence", want.packet_sequence,
                            rsp_mon.packet_sequence);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         predicted_results.delete();
         for (int i = 0; i < Links; i++) begin
            link_next_seq[i] = '0;
         end
         open_links    = '0;
         fail_count    = 0;
         lines_printed = 0;
         clear_parser();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            apply_link_mask(csr_mon.enabled_links);
         end
         if (req_mon.valid && req_mon.ready) begin
            parse_octet(req_mon.link_index, req_mon.rx_byte, req_mon.end_of_datagram,
                        req_mon.buffer_limit);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            check_result();
         end
      end
      pending_count = predicted_results.size();
   end

endmodule

// File: tb/datagram_sequence_filter_unit_tb.sv
// ----------------------------------------------------------------------------
// Datagram sequence filter testbench
// Sends directed and random datagrams, well-formed ones in the main, over a
// range of link masks and sender and receiver idle patterns. A checker beside
// the unit predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module datagram_sequence_filter_unit_tb;

   import dsf_pkg::*;

   localparam int Links          = DefaultLinks;
   localparam int PhaseOctets    = 150;
   localparam int QuietCycles    = 8;
   localparam int DrainLimit     = 20000;

   logic clock;
   logic reset;

   dsf_req_if req_bus ();
   dsf_rsp_if rsp_bus ();
   dsf_csr_if csr_bus ();

   int fail_count;
   int pending_count;

   datagram_sequence_filter_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   datagram_sequence_filter_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .csr_mon       (csr_bus),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   int                  sender_idle_pct;
   int                  receiver_stall_pct;
   int                  octets_sent;
   logic [7:0]          datagram[$];
   logic [EnabledW-1:0] link_mask;
   logic [SeqW-1:0]     next_seq [Links];

   always #10 clock = ~clock;

   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_octet(input logic [3:0] link, input logic [7:0] octet,
                             input logic last, input logic [10:0] limit);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.link_index      <= link;
      req_bus.rx_byte         <= octet;
      req_bus.end_of_datagram <= last;
      req_bus.buffer_limit    <= limit;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      octets_sent++;
      @(negedge clock);
   endtask

   task automatic build_datagram(input logic [31:0] magic, input logic [31:0] seq,
                                 input logic [15:0] count, input int payload);
      datagram.delete();
      for (int i = 3; i >= 0; i--) datagram.push_back(magic[8*i +: 8]);
      for (int i = 3; i >= 0; i--) datagram.push_back(seq[8*i +: 8]);
      datagram.push_back(count[15:8]);
      datagram.push_back(count[7:0]);
      for (int i = 0; i < payload; i++) datagram.push_back(8'($urandom_range(255)));
   endtask

   task automatic send_datagram(input logic [3:0] link, input logic [10:0] limit);
      for (int i = 0; i < datagram.size(); i++) begin
         send_octet(link, datagram[i], i == datagram.size() - 1, limit);
      end
      req_bus.valid <= 1'b0;
   endtask

   // Tracks what the link will expect next, so that most datagrams stay in order.
   task automatic note_accepted(input logic [3:0] link, input logic [31:0] seq);
      if (link < Links) begin
         if (link_mask[link] && (seq == 0 || seq >= next_seq[link])) begin
            next_seq[link] = seq + 32'd1;
         end
      end
   endtask

   task automatic wait_for_quiet();
      while (pending_count != 0) @(negedge clock);
      repeat (QuietCycles) @(negedge clock);
   endtask

   task automatic write_link_mask(input logic [EnabledW-1:0] value);
      csr_bus.valid         <= 1'b1;
      csr_bus.enabled_links <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      for (int i = 0; i < Links; i++) begin
         if (value[i] && !link_mask[i]) next_seq[i] = '0;
      end
      link_mask = value;
   endtask

   function automatic logic [3:0] pick_open_link();
      logic [3:0] cand;
      for (int i = 0; i < 8; i++) begin
         cand = 4'($urandom_range(Links - 1));
         if (link_mask[cand]) return cand;
      end
      return 4'($urandom_range(Links - 1));
   endfunction

   task automatic send_random_datagram();
      int          kind;
      int          words;
      int          payload;
      logic [3:0]  link;
      logic [10:0] limit;
      logic [31:0] seq;
      logic [31:0] magic;
      logic [15:0] count;
      logic        good;
      kind  = $urandom_range(99);
      link  = pick_open_link();
      words = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(4);
      case ($urandom_range(7))
         0:       limit = 11'd0;
         1:       limit = 11'd1024;
         2:       limit = 11'($urandom_range(1024));
         default: limit = 11'($urandom_range(4));
      endcase
      seq     = next_seq[link];
      magic   = MagicWord;
      count   = 16'(words);
      payload = 2 * words;
      good    = 1'b1;
      if (kind < 45) begin
         // in order, nothing to change
      end else if (kind < 55) begin
         seq = $urandom_range(1) ? seq + 32'($urandom_range(1, 1000)) : $urandom();
      end else if (kind < 62) begin
         seq = '0;
      end else if (kind < 69) begin
         seq = seq - 32'($urandom_range(1, 50));
      end else begin
         good = 1'b0;
         if (kind < 75) begin
            magic = magic ^ (32'd1 << $urandom_range(31));
         end else if (kind < 83) begin
            case ($urandom_range(3))
               0: payload = 2 * words + 1;
               1: payload = 2 * words + 2;
               2: payload = (words > 0) ? 2 * words - 1 : 3;
               default: count = 16'($urandom());
            endcase
         end else if (kind < 93) begin
            link = 4'($urandom_range(15));
            if (link < Links) begin
               if (link_mask[link]) link = 4'(Links + $urandom_range(15 - Links));
            end
         end
      end
      build_datagram(magic, seq, count, payload);
      if (kind >= 93) begin
         // truncated header or plain noise
         if (kind < 97) begin
            while (datagram.size() > $urandom_range(1, HdrBytes - 1))
               void'(datagram.pop_back());
         end else begin
            datagram.delete();
            repeat ($urandom_range(1, 24)) datagram.push_back(8'($urandom_range(255)));
         end
      end
      send_datagram(link, limit);
      if (good) note_accepted(link, seq);
   endtask

   task automatic send_good(input logic [3:0] link, input logic [31:0] seq,
                            input int words, input logic [10:0] limit);
      build_datagram(MagicWord, seq, 16'(words), 2 * words);
      send_datagram(link, limit);
      note_accepted(link, seq);
   endtask

   initial begin
      int                  start;
      int                  guard;
      logic [EnabledW-1:0] phase_mask [4];
      int                  idle_plan  [4];
      int                  stall_plan [4];

      clock                   = 1'b0;
      reset                   = 1'b1;
      req_bus.valid           = 1'b0;
      req_bus.link_index      = '0;
      req_bus.rx_byte         = '0;
      req_bus.end_of_datagram = 1'b0;
      req_bus.buffer_limit    = '0;
      rsp_bus.ready           = 1'b0;
      csr_bus.valid           = 1'b0;
      csr_bus.enabled_links   = '0;
      sender_idle_pct         = 0;
      receiver_stall_pct      = 0;
      octets_sent             = 0;
      link_mask               = '0;
      for (int i = 0; i < Links; i++) next_seq[i] = '0;
      phase_mask = '{10'h155, 10'h2AA, 10'($urandom_range(1023)), 10'h3FF};
      idle_plan  = '{0, 69, 0, 12};
      stall_plan = '{0, 0, 69, 12};

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_link_mask(10'h3FF);
      send_good(4'd0, 32'd0, 0, 11'd0);
      build_datagram(MagicWord, 32'd1, 16'd2, 0);
      datagram.push_back(8'hFF);
      datagram.push_back(8'hFF);
      datagram.push_back(8'h00);
      datagram.push_back(8'h00);
      send_datagram(4'd0, 11'd1);
      note_accepted(4'd0, 32'd1);
      send_good(4'd0, 32'd5, 1, 11'd4);             // gap
      send_good(4'd0, 32'd3, 1, 11'd4);             // stale
      send_good(4'd0, 32'd0, 1, 11'd4);             // remote restart
      send_good(4'd1, 32'hFFFF_FFFF, 0, 11'd1);     // expected wraps to zero
      send_good(4'd1, 32'd0, 1, 11'd2);
      build_datagram(MagicWord, 32'd7, 16'd0, 0);
      while (datagram.size() > 3) void'(datagram.pop_back());
      send_datagram(4'd2, 11'd0);
      while (datagram.size() > 1) void'(datagram.pop_back());
      send_datagram(4'd2, 11'd0);
      build_datagram(MagicWord ^ 32'd1, 32'd0, 16'd0, 0);
      send_datagram(4'd2, 11'd0);
      build_datagram(MagicWord, 32'd0, 16'd1, 3);   // odd trailing byte
      send_datagram(4'd2, 11'd3);
      build_datagram(MagicWord, 32'd0, 16'hFFFF, 2);
      send_datagram(4'd2, 11'd3);
      build_datagram(MagicWord, 32'd0, 16'd0, 0);
      send_datagram(4'd15, 11'd0);
      send_datagram(4'd10, 11'd0);
      wait_for_quiet();
      write_link_mask(10'h3F7);
      send_datagram(4'd3, 11'd0);
      wait_for_quiet();
      write_link_mask(10'h3FF);
      send_good(4'd4, 32'd0, 64, 11'd1024);         // a longer datagram
      build_datagram(MagicWord, 32'd1, 16'd64, 66);
      send_datagram(4'd4, 11'd2);                   // fewer bytes than its count
      wait_for_quiet();

      for (int phase = 0; phase < 4; phase++) begin
         if (phase == 2) begin
            write_link_mask('0);
            repeat (4) send_random_datagram();
            wait_for_quiet();
         end
         write_link_mask(phase_mask[phase]);
         sender_idle_pct    = idle_plan[phase];
         receiver_stall_pct = stall_plan[phase];
         start = octets_sent;
         while (octets_sent - start < PhaseOctets) send_random_datagram();
         wait_for_quiet();
      end

      guard = 0;
      while (pending_count != 0 && guard < DrainLimit) begin
         @(negedge clock);
         guard++;
      end
      repeat (QuietCycles) @(negedge clock);
      if (pending_count != 0) begin
         $display("%0d results never arrived", pending_count);
      end
      if (fail_count == 0 && pending_count == 0) begin
         $display("datagram_sequence_filter_unit verification clean");
      end else begin
         $display("datagram_sequence_filter_unit verification failed");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("datagram_sequence_filter_unit verification failed");
      $finish;
   end

endmodule

// File: files.f
design/dsf_pkg.sv
design/dsf_req_if.sv
design/dsf_rsp_if.sv
design/dsf_csr_if.sv
design/datagram_sequence_filter_unit.sv
tb/datagram_sequence_filter_checker.sv
tb/datagram_sequence_filter_unit_tb.sv
